// ===== design/bctt_pkg.sv =====
// Shared constants, codes and types of the block cache tag table.
package bctt_pkg;

   localparam int SLOTS_DEFAULT = 16;
   localparam int MAX_RES       = 16;

   localparam int CMD_W    = 3;
   localparam int BLK_W    = 32;
   localparam int TSIZE_W  = 5;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 4;
   localparam int USES_W   = 16;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 40;

   localparam logic [CMD_W-1:0] CMD_ACCESS   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SYNC     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_EVICT    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SYNC_ALL = 3'd3;
   localparam logic [CMD_W-1:0] CMD_PIN      = 3'd4;
   localparam logic [CMD_W-1:0] CMD_RELEASE  = 3'd5;

   localparam logic [STATUS_W-1:0] STS_HIT       = 3'd0;
   localparam logic [STATUS_W-1:0] STS_INSERTED  = 3'd1;
   localparam logic [STATUS_W-1:0] STS_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] STS_RANGE     = 3'd3;
   localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd4;
   localparam logic [STATUS_W-1:0] STS_PINNED    = 3'd5;
   localparam logic [STATUS_W-1:0] STS_WRITEBACK = 3'd6;

   localparam logic [1:0] SS_EMPTY = 2'd0;
   localparam logic [1:0] SS_USED  = 2'd1;
   localparam logic [1:0] SS_DEL   = 2'd2;

   localparam logic CSR_TABLE_SIZE  = 1'b0;
   localparam logic CSR_BLOCK_COUNT = 1'b1;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [BLK_W-1:0]    blk;
      logic                fill;
      logic                last;
   } result_type;

endpackage

// ===== design/bctt_div.sv =====
// Bit-serial remainder unit: 32-bit dividend modulo a 5-bit divisor.
module bctt_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bctt_pkg::BLK_W-1:0]    dividend,
   input  logic [bctt_pkg::TSIZE_W-1:0]  divisor,
   output logic                          done,
   output logic [bctt_pkg::TSIZE_W-1:0]  remainder
);
   import bctt_pkg::*;

   localparam int CNT_W = $clog2(BLK_W + 1);

   logic [BLK_W-1:0]   dvd_ff, dvd_in;
   logic [TSIZE_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               run_ff, run_in;
   logic               done_ff, done_in;
   logic [TSIZE_W:0]   trial;

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, dvd_ff[BLK_W-1]};
      if (start) begin
         dvd_in = dividend;
         rem_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         // restore step: subtract the divisor only if the trial value clears it
         if (trial >= {1'b0, divisor}) begin
            rem_in = TSIZE_W'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[TSIZE_W-1:0];
         end
         dvd_in = {dvd_ff[BLK_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(BLK_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== design/block_cache_tag_table_core.sv =====
// Top level of the block cache tag table: sequencer, slot store and result register.
// Operation: the shared remainder unit finds the home slot; evict goes straight to it, other
//   commands probe slots from there (up to the table size), then update; sync all sweeps
//   the slots in turn. Stalls on the result side hold the sequencer.
// Requests: one request at a time; an unknown command is accepted and dropped at once.
// Reset (synchronous, active high): slots empty, registers at defaults.
module block_cache_tag_table_core #(
   parameter int SLOTS = bctt_pkg::SLOTS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // block_number[31:0], write_intent[32], skip_fill[33], victim_seed[65:34]
   input  logic [bctt_pkg::REQ_DATA_W-1:0]   req_tdata,
   // command[2:0]
   input  logic [bctt_pkg::CMD_W-1:0]        req_tuser,
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // slot[3:0], slot_block[35:4], need_fill[36]
   output logic [bctt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // status[2:0]
   output logic [bctt_pkg::STATUS_W-1:0]     rsp_tuser,
   output logic                              rsp_tlast,
   // configuration writes
   input  logic                              csr_we,
   input  logic                              csr_addr,
   input  logic [bctt_pkg::BLK_W-1:0]        csr_wdata
);
   import bctt_pkg::*;

   // only the first sixteen slots can ever be addressed
   localparam int DEPTH = (SLOTS < MAX_RES) ? SLOTS : MAX_RES;
   localparam int IW    = $clog2(DEPTH);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DIV      = 3'd1;
   localparam logic [2:0] S_PROBE    = 3'd2;
   localparam logic [2:0] S_ACT      = 3'd3;
   localparam logic [2:0] S_SYNC_FIN = 3'd4;
   localparam logic [2:0] S_SALL     = 3'd5;
   localparam logic [2:0] S_SALL_END = 3'd6;

   // configuration
   logic [TSIZE_W-1:0] table_size_ff;
   logic [BLK_W-1:0]   block_count_ff;
   logic [TSIZE_W-1:0] eff_n;

   // request held for the whole operation
   logic [CMD_W-1:0] cmd_ff;
   logic [BLK_W-1:0] blk_ff;
   logic             wr_ff, skip_ff;

   // sequencer
   logic [2:0]         state_ff, state_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [TSIZE_W-1:0] cnt_ff, cnt_in;
   logic [IW-1:0]      free_ff, free_in;
   logic               free_vld_ff, free_vld_in;
   logic [IW-1:0]      tgt_ff, tgt_in;
   logic               found_ff, found_in;
   logic               sawb_ff, sawb_in;

   // slot store
   logic [1:0]        slot_state_ff  [DEPTH];
   logic [BLK_W-1:0]  slot_tag_ff    [DEPTH];
   logic              slot_dirty_ff  [DEPTH];
   logic              slot_loaded_ff [DEPTH];
   logic              slot_pinned_ff [DEPTH];
   logic [USES_W-1:0] slot_uses_ff   [DEPTH];

   logic              wr_en, tag_we;
   logic [IW-1:0]     rd_idx;
   logic [1:0]        wr_state_in;
   logic              wr_dirty_in, wr_loaded_in, wr_pinned_in;
   logic [USES_W-1:0] wr_uses_in, uses_inc;
   logic [1:0]        rd_state;
   logic [BLK_W-1:0]  rd_tag;
   logic              rd_dirty, rd_loaded, rd_pinned;
   logic [USES_W-1:0] rd_uses;
   logic [IW-1:0]     idx_next, home;
   logic              later_dirty;

   // result register
   logic       rsp_valid_ff;
   result_type rsp_ff, emit;
   logic       emit_req, can_emit;

   // remainder unit
   logic               req_acc, div_start, div_done;
   logic [TSIZE_W-1:0] div_rem;
   logic [BLK_W-1:0]   div_dvd;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign can_emit   = !rsp_valid_ff || rsp_tready;

   // table size zero counts as one; clamp to the slots that exist
   always_comb begin
      if (table_size_ff == '0) begin
         eff_n = TSIZE_W'(1);
      end else if (table_size_ff > TSIZE_W'(DEPTH)) begin
         eff_n = TSIZE_W'(DEPTH);
      end else begin
         eff_n = table_size_ff;
      end
   end

   assign div_start = req_acc && (req_tuser <= CMD_RELEASE) && (req_tuser != CMD_SYNC_ALL);
   assign div_dvd   = (req_tuser == CMD_EVICT) ? req_tdata[65:34] : req_tdata[31:0];

   bctt_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (eff_n),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign home     = div_rem[IW-1:0];
   assign idx_next = (TSIZE_W'(idx_ff) + 1'b1 == eff_n) ? '0 : idx_ff + 1'b1;

   // pick the slot the current step looks at
   always_comb begin
      if (state_ff == S_ACT || state_ff == S_SYNC_FIN) begin
         rd_idx = (cmd_ff == CMD_ACCESS && !found_ff) ? free_ff : tgt_ff;
      end else begin
         rd_idx = idx_ff;
      end
   end

   assign rd_state  = slot_state_ff[rd_idx];
   assign rd_tag    = slot_tag_ff[rd_idx];
   assign rd_dirty  = slot_dirty_ff[rd_idx];
   assign rd_loaded = slot_loaded_ff[rd_idx];
   assign rd_pinned = slot_pinned_ff[rd_idx];
   assign rd_uses   = slot_uses_ff[rd_idx];
   assign uses_inc  = (rd_uses == '1) ? rd_uses : rd_uses + 1'b1;

   // any dirty used slot still ahead in a sync-all sweep decides the last mark
   always_comb begin
      later_dirty = 1'b0;
      for (int j = 0; j < DEPTH; j++) begin
         if (TSIZE_W'(j) > TSIZE_W'(idx_ff) && TSIZE_W'(j) < eff_n &&
             slot_state_ff[j] == SS_USED && slot_dirty_ff[j]) begin
            later_dirty = 1'b1;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      free_in      = free_ff;
      free_vld_in  = free_vld_ff;
      tgt_in       = tgt_ff;
      found_in     = found_ff;
      sawb_in      = sawb_ff;
      emit_req     = 1'b0;
      emit         = '0;
      wr_en        = 1'b0;
      tag_we       = 1'b0;
      wr_state_in  = rd_state;
      wr_dirty_in  = rd_dirty;
      wr_loaded_in = rd_loaded;
      wr_pinned_in = rd_pinned;
      wr_uses_in   = rd_uses;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (req_tuser == CMD_SYNC_ALL) begin
                  state_in = S_SALL;
                  idx_in   = '0;
                  sawb_in  = 1'b0;
               end else if (req_tuser <= CMD_RELEASE) begin
                  state_in = S_DIV;
               end
            end
         end

         S_DIV: begin
            if (div_done) begin
               if (cmd_ff == CMD_EVICT) begin
                  tgt_in   = home;
                  found_in = (slot_state_ff[home] == SS_USED);
                  state_in = S_ACT;
               end else begin
                  idx_in      = home;
                  cnt_in      = '0;
                  free_vld_in = 1'b0;
                  found_in    = 1'b0;
                  state_in    = S_PROBE;
               end
            end
         end

         S_PROBE: begin
            // remember the first claimable slot on the way
            if (rd_state != SS_USED && !free_vld_ff) begin
               free_in     = idx_ff;
               free_vld_in = 1'b1;
            end
            if (rd_state == SS_EMPTY) begin
               state_in = S_ACT;
            end else if (rd_state == SS_USED && rd_tag == blk_ff) begin
               found_in = 1'b1;
               tgt_in   = idx_ff;
               state_in = S_ACT;
            end else if (cnt_ff == eff_n - 1'b1) begin
               state_in = S_ACT;
            end else begin
               idx_in = idx_next;
               cnt_in = cnt_ff + 1'b1;
            end
         end

         S_ACT: begin
            unique case (cmd_ff)
               CMD_ACCESS: begin
                  emit_req  = 1'b1;
                  emit.last = 1'b1;
                  if (blk_ff >= block_count_ff) begin
                     emit.status = STS_RANGE;
                  end else if (found_ff) begin
                     emit.status  = STS_HIT;
                     emit.slot    = SLOT_W'(rd_idx);
                     emit.blk     = rd_tag;
                     emit.fill    = !rd_loaded && !skip_ff;
                     wr_en        = can_emit;
                     wr_uses_in   = uses_inc;
                     wr_loaded_in = 1'b1;
                     wr_dirty_in  = rd_dirty || wr_ff;
                  end else if (free_vld_ff) begin
                     emit.status  = STS_INSERTED;
                     emit.slot    = SLOT_W'(rd_idx);
                     emit.blk     = blk_ff;
                     emit.fill    = !skip_ff;
                     wr_en        = can_emit;
                     tag_we       = can_emit;
                     wr_state_in  = SS_USED;
                     wr_uses_in   = uses_inc;
                     wr_loaded_in = 1'b1;
                     wr_dirty_in  = wr_ff;
                  end else begin
                     emit.status = STS_FULL;
                  end
                  if (can_emit) begin
                     state_in = S_IDLE;
                  end
               end
               CMD_SYNC, CMD_EVICT: begin
                  if (!found_ff) begin
                     emit_req    = 1'b1;
                     emit.status = STS_NOT_FOUND;
                     emit.last   = 1'b1;
                     if (can_emit) begin
                        state_in = S_IDLE;
                     end
                  end else if (rd_dirty) begin
                     // write back first, the final result follows
                     emit_req    = 1'b1;
                     emit.status = STS_WRITEBACK;
                     emit.slot   = SLOT_W'(rd_idx);
                     emit.blk    = rd_tag;
                     wr_en       = can_emit;
                     wr_dirty_in = 1'b0;
                     if (can_emit) begin
                        state_in = S_SYNC_FIN;
                     end
                  end else begin
                     state_in = S_SYNC_FIN;
                  end
               end
               CMD_PIN, CMD_RELEASE: begin
                  emit_req  = 1'b1;
                  emit.last = 1'b1;
                  if (found_ff) begin
                     emit.status  = STS_HIT;
                     emit.slot    = SLOT_W'(rd_idx);
                     emit.blk     = rd_tag;
                     wr_en        = can_emit;
                     wr_pinned_in = (cmd_ff == CMD_PIN);
                  end else begin
                     emit.status = STS_NOT_FOUND;
                  end
                  if (can_emit) begin
                     state_in = S_IDLE;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         S_SYNC_FIN: begin
            emit_req  = 1'b1;
            emit.last = 1'b1;
            emit.slot = SLOT_W'(rd_idx);
            emit.blk  = rd_tag;
            if (rd_pinned) begin
               emit.status = STS_PINNED;
            end else begin
               emit.status  = STS_HIT;
               wr_en        = can_emit;
               wr_state_in  = SS_DEL;
               wr_dirty_in  = 1'b0;
               wr_loaded_in = 1'b0;
               wr_uses_in   = '0;
            end
            if (can_emit) begin
               state_in = S_IDLE;
            end
         end

         S_SALL: begin
            if (rd_state == SS_USED && rd_dirty) begin
               emit_req    = 1'b1;
               emit.status = STS_WRITEBACK;
               emit.slot   = SLOT_W'(idx_ff);
               emit.blk    = rd_tag;
               emit.last   = !later_dirty;
            end
            // hold the sweep while a write-back cannot be handed over
            if (!emit_req || can_emit) begin
               if (rd_state == SS_USED) begin
                  wr_en       = 1'b1;
                  wr_dirty_in = 1'b0;
                  if (!rd_pinned) begin
                     wr_state_in  = SS_DEL;
                     wr_loaded_in = 1'b0;
                     wr_uses_in   = '0;
                  end
               end
               if (emit_req) begin
                  sawb_in = 1'b1;
               end
               if (TSIZE_W'(idx_ff) == eff_n - 1'b1) begin
                  state_in = (sawb_ff || emit_req) ? S_IDLE : S_SALL_END;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end

         S_SALL_END: begin
            emit_req    = 1'b1;
            emit.status = STS_HIT;
            emit.last   = 1'b1;
            if (can_emit) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         table_size_ff  <= TSIZE_W'(16);
         block_count_ff <= '1;
         found_ff       <= 1'b0;
         free_vld_ff    <= 1'b0;
         sawb_ff        <= 1'b0;
         for (int i = 0; i < DEPTH; i++) begin
            slot_state_ff[i]  <= SS_EMPTY;
            slot_dirty_ff[i]  <= 1'b0;
            slot_loaded_ff[i] <= 1'b0;
            slot_pinned_ff[i] <= 1'b0;
            slot_uses_ff[i]   <= '0;
         end
      end else begin
         state_ff    <= state_in;
         found_ff    <= found_in;
         free_vld_ff <= free_vld_in;
         sawb_ff     <= sawb_in;
         if (emit_req && can_emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (csr_addr)
               CSR_TABLE_SIZE:  table_size_ff  <= csr_wdata[TSIZE_W-1:0];
               CSR_BLOCK_COUNT: block_count_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (wr_en) begin
            slot_state_ff[rd_idx]  <= wr_state_in;
            slot_dirty_ff[rd_idx]  <= wr_dirty_in;
            slot_loaded_ff[rd_idx] <= wr_loaded_in;
            slot_pinned_ff[rd_idx] <= wr_pinned_in;
            slot_uses_ff[rd_idx]   <= wr_uses_in;
         end
      end
      idx_ff  <= idx_in;
      cnt_ff  <= cnt_in;
      free_ff <= free_in;
      tgt_ff  <= tgt_in;
      if (tag_we) begin
         slot_tag_ff[rd_idx] <= blk_ff;
      end
      if (req_acc) begin
         cmd_ff  <= req_tuser;
         blk_ff  <= req_tdata[31:0];
         wr_ff   <= req_tdata[32];
         skip_ff <= req_tdata[33];
      end
      if (emit_req && can_emit) begin
         rsp_ff <= emit;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {3'b000, rsp_ff.fill, rsp_ff.blk, rsp_ff.slot};

   // busy after every request that yields a result
   assert property (@(posedge clock) disable iff (reset)
      req_acc && req_tuser <= CMD_RELEASE |=> !req_tready)
      else $error("request channel still ready after a valid command");

   // the effective table size is never zero
   assert property (@(posedge clock) disable iff (reset) eff_n != '0)
      else $error("effective table size is zero");

   // probe and sweep stay inside the table
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE || state_ff == S_SALL) |-> TSIZE_W'(idx_ff) < eff_n)
      else $error("slot index beyond table size");

   // the remainder unit only finishes while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset) div_done |-> state_ff == S_DIV)
      else $error("remainder ready outside the divide step");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the block cache tag table core.
`timescale 1ns / 100ps

module tb;
   import bctt_pkg::*;

   localparam int NSLOTS      = SLOTS_DEFAULT;
   localparam int IDLE_LIMIT  = 5000;   // cycles with no item moving on either side
   localparam int SETTLE      = 80;     // quiet cycles before a register write
   localparam int LONG_HOLD   = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [CMD_W-1:0]      req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic rsp_tlast;
   logic csr_we = 1'b0;
   logic csr_addr = CSR_TABLE_SIZE;
   logic [BLK_W-1:0] csr_wdata = '0;

   always #4 clock = ~clock;

   block_cache_tag_table_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   // ---------------------------------------------------------------
   // Shadow copy of the tag table
   // ---------------------------------------------------------------
   logic [1:0]        tag_state  [NSLOTS];
   logic [BLK_W-1:0]  tag_block  [NSLOTS];
   logic              tag_dirty  [NSLOTS];
   logic              tag_loaded [NSLOTS];
   logic              tag_pinned [NSLOTS];
   logic [USES_W-1:0] tag_uses   [NSLOTS];
   logic [TSIZE_W-1:0] shadow_size  = 5'd16;
   logic [BLK_W-1:0]   shadow_count = 32'hFFFF_FFFF;

   result_type step_results[$];     // results of the request being predicted
   result_type awaited_results[$];  // results still owed by the block

   int mismatches = 0;
   int hold_asks = 0;
   int hold_seen = 0;
   int idle_cycles = 0;

   initial begin
      for (int i = 0; i < NSLOTS; i++) begin
         tag_state[i] = SS_EMPTY; tag_block[i] = '0; tag_dirty[i] = 1'b0;
         tag_loaded[i] = 1'b0; tag_pinned[i] = 1'b0; tag_uses[i] = '0;
      end
   end

   function automatic int live_slots();
      int n;
      n = (shadow_size == 0) ? 1 : int'(shadow_size);
      if (n > NSLOTS) n = NSLOTS;
      return n;
   endfunction

   function automatic void post(logic [STATUS_W-1:0] st, int s, logic [BLK_W-1:0] blk,
                                logic fill);
      result_type r;
      r.status = st; r.slot = s[SLOT_W-1:0]; r.blk = blk; r.fill = fill; r.last = 1'b0;
      step_results.push_back(r);
   endfunction

   function automatic int find_block(logic [BLK_W-1:0] blk, int n);
      int idx;
      idx = int'(blk % n);
      for (int i = 0; i < n; i++) begin
         if (tag_state[idx] == SS_EMPTY) return -1;
         if (tag_state[idx] == SS_USED && tag_block[idx] == blk) return idx;
         idx = (idx + 1) % n;
      end
      return -1;
   endfunction

   function automatic void release_slot(int s);
      tag_state[s] = SS_DEL; tag_dirty[s] = 1'b0; tag_loaded[s] = 1'b0; tag_uses[s] = '0;
   endfunction

   function automatic void flush_dirty(int s);
      if (tag_dirty[s]) begin
         post(STS_WRITEBACK, s, tag_block[s], 1'b0);
         tag_dirty[s] = 1'b0;
      end
   endfunction

   function automatic void sync_slot(int s);
      flush_dirty(s);
      if (tag_pinned[s]) post(STS_PINNED, s, tag_block[s], 1'b0);
      else begin
         release_slot(s);
         post(STS_HIT, s, tag_block[s], 1'b0);
      end
   endfunction

   function automatic void touch_slot(int s, logic [STATUS_W-1:0] st, logic wr, logic skip);
      logic fill;
      if (tag_uses[s] != 16'hFFFF) tag_uses[s] = tag_uses[s] + 1'b1;
      fill = !tag_loaded[s] && !skip;
      tag_loaded[s] = 1'b1;
      if (wr) tag_dirty[s] = 1'b1;
      post(st, s, tag_block[s], fill);
   endfunction

   // Work out the results of one request and update the shadow table.
   function automatic void predict_request(logic [CMD_W-1:0] cmd, logic [BLK_W-1:0] blk,
                                           logic wr, logic skip, logic [BLK_W-1:0] seed);
      int n, f, idx, i;
      n = live_slots();
      step_results.delete();
      case (cmd)
         CMD_ACCESS: begin
            if (blk >= shadow_count) post(STS_RANGE, 0, '0, 1'b0);
            else begin
               f = find_block(blk, n);
               if (f >= 0) touch_slot(f, STS_HIT, wr, skip);
               else begin
                  idx = int'(blk % n);
                  for (i = 0; i < n; i++) begin
                     if (tag_state[idx] != SS_USED) break;
                     idx = (idx + 1) % n;
                  end
                  if (i == n) post(STS_FULL, 0, '0, 1'b0);
                  else begin
                     tag_state[idx] = SS_USED; tag_block[idx] = blk;
                     tag_dirty[idx] = 1'b0; tag_loaded[idx] = 1'b0;
                     touch_slot(idx, STS_INSERTED, wr, skip);
                  end
               end
            end
         end
         CMD_SYNC: begin
            f = find_block(blk, n);
            if (f < 0) post(STS_NOT_FOUND, 0, '0, 1'b0);
            else sync_slot(f);
         end
         CMD_EVICT: begin
            idx = int'(seed % n);
            if (tag_state[idx] != SS_USED) post(STS_NOT_FOUND, 0, '0, 1'b0);
            else sync_slot(idx);
         end
         CMD_SYNC_ALL: begin
            for (i = 0; i < n; i++) begin
               if (tag_state[i] == SS_USED) begin
                  flush_dirty(i);
                  if (!tag_pinned[i]) release_slot(i);
               end
            end
            if (step_results.size() == 0) post(STS_HIT, 0, '0, 1'b0);
         end
         CMD_PIN, CMD_RELEASE: begin
            f = find_block(blk, n);
            if (f < 0) post(STS_NOT_FOUND, 0, '0, 1'b0);
            else begin
               tag_pinned[f] = (cmd == CMD_PIN);
               post(STS_HIT, f, tag_block[f], 1'b0);
            end
         end
         default: ;  // unknown command: no result, no change
      endcase
      if (step_results.size() > 0) step_results[step_results.size()-1].last = 1'b1;
   endfunction

   // ---------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------
   int burst_left = 0;

   // Offer one request, hold it until accepted, then predict its results.
   task automatic offer_request(logic [CMD_W-1:0] cmd, logic [BLK_W-1:0] blk, logic wr,
                                logic skip, logic [BLK_W-1:0] seed,
                                int typed = 0, result_type typed_res = '0);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         // idle between bursts, sometimes not at all
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 10);
      end
      burst_left--;
      req_tuser  = cmd;
      req_tdata  = '0;
      req_tdata[65:0] = {seed, skip, wr, blk};
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_request(cmd, blk, wr, skip, seed);
      // rows with a hand-written expectation take it in place of the prediction
      if (typed == 1) begin
         step_results.delete();
         step_results.push_back(typed_res);
      end else if (typed == 2) step_results.delete();
      foreach (step_results[k]) awaited_results.push_back(step_results[k]);
   endtask

   // Hold the sender until every awaited result is back and the block is quiet.
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      burst_left = 0;
      while (awaited_results.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_csr(logic addr, logic [BLK_W-1:0] value);
      drain();
      csr_we = 1'b1; csr_addr = addr; csr_wdata = value;
      if (addr == CSR_TABLE_SIZE) shadow_size = value[TSIZE_W-1:0];
      else shadow_count = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Directed table
   typedef struct {
      logic [CMD_W-1:0] cmd;
      logic [BLK_W-1:0] blk;
      logic             wr;
      logic             skip;
      logic [BLK_W-1:0] seed;
      int               typed;   // 0 predicted, 1 typed result, 2 no result
      result_type       res;
   } stim_row_type;

   stim_row_type directed[$];

   function automatic void add_row(logic [CMD_W-1:0] cmd, logic [BLK_W-1:0] blk, logic wr,
                                   logic skip, logic [BLK_W-1:0] seed, int typed = 0,
                                   logic [STATUS_W-1:0] st = STS_HIT, int s = 0,
                                   logic [BLK_W-1:0] sb = '0, logic fill = 1'b0);
      stim_row_type r;
      r.cmd = cmd; r.blk = blk; r.wr = wr; r.skip = skip; r.seed = seed; r.typed = typed;
      r.res.status = st; r.res.slot = s[SLOT_W-1:0]; r.res.blk = sb;
      r.res.fill = fill; r.res.last = 1'b1;
      directed.push_back(r);
   endfunction

   // Random requests drawn mostly from a small pool of block numbers so hits happen.
   task automatic random_phase(int count, bit with_hold);
      logic [BLK_W-1:0] pool[12];
      logic [BLK_W-1:0] blk;
      logic [CMD_W-1:0] cmd;
      int pick;
      foreach (pool[i]) begin
         if (shadow_count == 32'hFFFF_FFFF)
            pool[i] = (i < 6) ? $urandom_range(0, 40) : $urandom();
         else pool[i] = $urandom_range(0, shadow_count);
      end
      for (int k = 0; k < count; k++) begin
         if (with_hold && k == count / 3) hold_asks++;
         blk = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 11)] : $urandom();
         pick = $urandom_range(0, 99);
         if (pick < 45)      cmd = CMD_ACCESS;
         else if (pick < 57) cmd = CMD_SYNC;
         else if (pick < 67) cmd = CMD_EVICT;
         else if (pick < 72) cmd = CMD_SYNC_ALL;
         else if (pick < 84) cmd = CMD_PIN;
         else if (pick < 96) cmd = CMD_RELEASE;
         else                cmd = CMD_W'($urandom_range(6, 7));
         offer_request(cmd, blk, 1'($urandom()), 1'($urandom()), $urandom());
      end
   endtask

   initial begin
      // directed rows at reset settings: 16 slots, every block number below all-ones
      add_row(CMD_ACCESS, 32'd0, 0, 0, 0, 1, STS_INSERTED, 0, 32'd0, 1'b1);
      add_row(CMD_ACCESS, 32'd0, 0, 0, 0, 1, STS_HIT, 0, 32'd0, 1'b0);
      add_row(CMD_ACCESS, 32'hFFFF_FFFF, 1, 1, 0, 1, STS_RANGE);
      add_row(CMD_ACCESS, 32'hFFFF_FFFE, 1, 1, 32'hFFFF_FFFF);
      add_row(CMD_ACCESS, 32'd16, 1, 0, 0);          // collides with slot 0
      add_row(CMD_ACCESS, 32'd32, 0, 1, 0);
      add_row(CMD_SYNC, 32'd0, 0, 0, 0);             // frees slot 0, leaves it deleted
      add_row(CMD_ACCESS, 32'd32, 1, 0, 0);          // hit probed past the deleted slot
      add_row(CMD_PIN, 32'd16, 0, 0, 0);
      add_row(CMD_SYNC, 32'd16, 0, 0, 0);            // writeback then pinned
      add_row(CMD_EVICT, 32'd0, 0, 0, 32'd1);        // pinned slot refuses eviction
      add_row(CMD_RELEASE, 32'd16, 0, 0, 0);
      add_row(CMD_EVICT, 32'd0, 0, 0, 32'd17);
      add_row(CMD_PIN, 32'd12345, 0, 0, 0, 1, STS_NOT_FOUND);
      add_row(CMD_RELEASE, 32'd777, 0, 0, 0, 1, STS_NOT_FOUND);
      add_row(CMD_W'(6), 32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF, 2);
      add_row(CMD_W'(7), 32'd0, 0, 0, 0, 2);
      add_row(CMD_ACCESS, 32'd5, 1, 0, 0);
      add_row(CMD_PIN, 32'd5, 0, 0, 0);
      add_row(CMD_SYNC_ALL, 32'd0, 0, 0, 0);
      add_row(CMD_SYNC_ALL, 32'd0, 0, 0, 0);
      add_row(CMD_SYNC, 32'd99, 0, 0, 0, 1, STS_NOT_FOUND);
      add_row(CMD_EVICT, 32'd0, 0, 0, 32'hFFFF_FFFF);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i])
         offer_request(directed[i].cmd, directed[i].blk, directed[i].wr, directed[i].skip,
                       directed[i].seed, directed[i].typed, directed[i].res);

      // full table, whole block range, with one long stall on the result side
      random_phase(90, 1);
      write_csr(CSR_TABLE_SIZE, 32'd3);
      write_csr(CSR_BLOCK_COUNT, 32'd40);
      random_phase(50, 0);
      write_csr(CSR_TABLE_SIZE, 32'd0);              // counts as one slot
      write_csr(CSR_BLOCK_COUNT, 32'd1);
      random_phase(20, 0);
      write_csr(CSR_TABLE_SIZE, 32'd31);             // saturates to the slot count
      write_csr(CSR_BLOCK_COUNT, 32'd1000);
      random_phase(70, 1);
      write_csr(CSR_TABLE_SIZE, 32'd7);
      write_csr(CSR_BLOCK_COUNT, 32'd0);             // every access out of range
      random_phase(10, 0);
      write_csr(CSR_TABLE_SIZE, 32'd5);
      write_csr(CSR_BLOCK_COUNT, 32'h8000_0000);
      random_phase(50, 0);

      drain();
      if (mismatches == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   // ---------------------------------------------------------------
   // Receiver side: stall pattern of its own, plus long hold-offs on request
   // ---------------------------------------------------------------
   int hold_left = 0;
   int stall_phase = 0;

   always @(negedge clock) begin
      if (reset) rsp_tready = 1'b0;
      else if (hold_left > 0) begin
         rsp_tready = 1'b0;
         hold_left--;
      end else if (hold_seen != hold_asks) begin
         hold_seen = hold_asks;
         hold_left = LONG_HOLD;
         rsp_tready = 1'b0;
      end else begin
         stall_phase = (stall_phase + 1) % 96;
         // alternate a stretch of steady acceptance with a stretch of random stalls
         rsp_tready = (stall_phase < 40) ? 1'b1 : ($urandom_range(0, 2) != 0);
      end
   end

   // Compare each accepted result with the oldest awaited one.
   always @(posedge clock) begin
      result_type seen, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.status = rsp_tuser; seen.slot = rsp_tdata[3:0]; seen.blk = rsp_tdata[35:4];
         seen.fill = rsp_tdata[36]; seen.last = rsp_tlast;
         if (awaited_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: status %0d slot %0d block %h fill %b last %b",
                        seen.status, seen.slot, seen.blk, seen.fill, seen.last);
         end else begin
            want = awaited_results.pop_front();
            if (seen !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $write("mismatch: exp status %0d slot %0d block %h fill %b last %b, ",
                         want.status, want.slot, want.blk, want.fill, want.last);
                  $display("got status %0d slot %0d block %h fill %b last %b",
                           seen.status, seen.slot, seen.blk, seen.fill, seen.last);
               end
            end
         end
      end
   end

   // Watchdog: end the run if nothing moves for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

endmodule
